>>> sv/msg_pkg.sv
// ----------------------------------------------------------------------------
// msg_pkg: shared types, constants and helpers of the tile geometry unit
// Holds the configuration record, placement codes, divider step function and
// the stack extent functions used by several pipeline stages.
// ----------------------------------------------------------------------------
package msg_pkg;

    localparam int MAX_TILES  = 256;
    localparam int BORDER_PX  = 1;
    localparam int MIN_TILE_W = 100;

    localparam int CNT_W   = 9;     // tile_count width
    localparam int IDX_W   = 8;     // tile_index width
    localparam int COORD_W = 18;    // result width
    localparam int DIV_W   = 8;     // divisor width, count - 1
    localparam int QUO_W   = 16;    // magnitude of the stack extent
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS_PER_STAGE;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic signed [COORD_W-1:0] B2 = COORD_W'(2 * BORDER_PX);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        PL_SINGLE   = 2'd0,
        PL_MASTER   = 2'd1,
        PL_STACK    = 2'd2,
        PL_FALLBACK = 2'd3
    } placement_t;

    typedef enum logic [1:0] {
        SP_LEFT   = 2'd0,
        SP_BOTTOM = 2'd1,
        SP_RIGHT  = 2'd2
    } stack_pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_X       = 3'd0,
        CFG_SCREEN_Y       = 3'd1,
        CFG_SCREEN_W       = 3'd2,
        CFG_SCREEN_H       = 3'd3,
        CFG_BAR_H          = 3'd4,
        CFG_MASTER_SIZE    = 3'd5,
        CFG_STACK_POS      = 3'd6,
        CFG_STACK_VERTICAL = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [14:0] screen_x;
        logic [14:0] screen_y;
        logic [14:0] screen_w;
        logic [14:0] screen_h;
        logic [9:0]  bar_h;
        logic [14:0] master_size;
        stack_pos_t  stack_pos;
        logic        stack_vertical;
    } cfg_t;

    // Request state while the stack extent is divided by count - 1
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] idx;
        logic             neg;
        logic [DIV_W-1:0] d;
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] dq;    // dividend bits shift out, quotient bits in
    } div_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] idx;
        coord_t           th;
        coord_t           tw;
        coord_t           prod;
        logic             tile_ok;
    } geo_t;

    function automatic coord_t ext15(input logic [14:0] v);
        ext15 = $signed({3'b000, v});
    endfunction

    function automatic coord_t stack_w(input cfg_t c);
        if (c.stack_pos == SP_BOTTOM)
            stack_w = ext15(c.screen_w);
        else
            stack_w = ext15(c.screen_w) - ext15(c.master_size);
    endfunction

    function automatic coord_t stack_h(input cfg_t c);
        coord_t bh;
        bh = $signed({8'b0, c.bar_h});
        if (c.stack_pos == SP_BOTTOM)
            stack_h = ext15(c.screen_h) - bh - ext15(c.master_size);
        else
            stack_h = ext15(c.screen_h) - bh;
    endfunction

    // One restoring division step
    function automatic div_t div_step(input div_t s);
        div_t             r;
        logic [DIV_W:0]   trial;
        r = s;
        trial = {s.rem, s.dq[QUO_W-1]};
        if (trial >= {1'b0, s.d})
        begin
            trial = trial - {1'b0, s.d};
            r.dq  = {s.dq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.dq  = {s.dq[QUO_W-2:0], 1'b0};
        end
        r.rem = trial[DIV_W-1:0];
        div_step = r;
    endfunction

endpackage

>>> sv/msg_req_if.sv
// ----------------------------------------------------------------------------
// msg_req_if: request channel of the tile geometry unit
// Carries one tile count and window index per request.
// ----------------------------------------------------------------------------
interface msg_req_if;
    logic       valid;
    logic       ready;
    logic [8:0] tile_count;
    logic [7:0] tile_index;

    modport source (output valid, output tile_count, output tile_index, input ready);
    modport sink   (input valid, input tile_count, input tile_index, output ready);
endinterface

>>> sv/msg_rsp_if.sv
// ----------------------------------------------------------------------------
// msg_rsp_if: response channel of the tile geometry unit
// Carries the window rectangle and its placement kind.
// ----------------------------------------------------------------------------
interface msg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] size_w;
    logic signed [17:0] size_h;
    logic [1:0]         placement;

    modport source (output valid, output pos_x, output pos_y, output size_w,
                    output size_h, output placement, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input size_w,
                    input size_h, input placement, output ready);
endinterface

>>> sv/master_stack_tile_geometry_unit.sv
// ----------------------------------------------------------------------------
// master_stack_tile_geometry_unit: master/stack window rectangle generator
// Returns x, y, width, height and placement kind for one tiled window.
// ----------------------------------------------------------------------------
// Usage:
//   req carries tile_count and tile_index; rsp returns one rectangle per
//   request, in request order. Screen geometry, bar height, master size
//   and stack layout are loaded through cfg_wr_en/cfg_index/cfg_data and
//   may only change while no request is in flight.
//   A request passes one entry stage, four divider stages of four quotient
//   bits each (stack extent / count - 1), one multiply stage and the
//   output register.
//   One request per cycle is taken while the response side keeps up.
//   When rsp is stalled with a response waiting, the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the default 1920x1080 layout with
//   a 20 pixel bar, 1152 pixel master and a vertical stack on the right.
// ----------------------------------------------------------------------------
module master_stack_tile_geometry_unit
    import msg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    msg_req_if.sink               req,
    msg_rsp_if.source             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       adv;
    logic       dv [DIV_STAGES+1];
    div_t       dd [DIV_STAGES+1];
    coord_t     px, py, sw, sh;
    placement_t pl;
    logic       out_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCREEN_X:       cfg_next.screen_x    = cfg_data;
                CFG_SCREEN_Y:       cfg_next.screen_y    = cfg_data;
                CFG_SCREEN_W:       cfg_next.screen_w    = cfg_data;
                CFG_SCREEN_H:       cfg_next.screen_h    = cfg_data;
                CFG_BAR_H:          cfg_next.bar_h       = cfg_data[9:0];
                CFG_MASTER_SIZE:    cfg_next.master_size = cfg_data;
                CFG_STACK_POS:
                begin
                    // the unused code acts as right
                    if (cfg_data[1:0] == 2'b11)
                        cfg_next.stack_pos = SP_RIGHT;
                    else
                        cfg_next.stack_pos = stack_pos_t'(cfg_data[1:0]);
                end
                CFG_STACK_VERTICAL: cfg_next.stack_vertical = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_x       <= 15'd0;
            cfg_reg.screen_y       <= 15'd0;
            cfg_reg.screen_w       <= 15'd1920;
            cfg_reg.screen_h       <= 15'd1080;
            cfg_reg.bar_h          <= 10'd20;
            cfg_reg.master_size    <= 15'd1152;
            cfg_reg.stack_pos      <= SP_RIGHT;
            cfg_reg.stack_vertical <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance everything unless a response waits on a stalled receiver
    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;

    msg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (req.valid),
        .in_count  (req.tile_count),
        .in_index  (req.tile_index),
        .out_valid (dv[0]),
        .out_data  (dd[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        msg_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv[g]),
            .in_data   (dd[g]),
            .out_valid (dv[g+1]),
            .out_data  (dd[g+1])
        );
    end

    msg_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (dv[DIV_STAGES]),
        .in_data   (dd[DIV_STAGES]),
        .out_valid (out_valid),
        .pos_x     (px),
        .pos_y     (py),
        .size_w    (sw),
        .size_h    (sh),
        .placement (pl)
    );

    assign rsp.valid     = out_valid;
    assign rsp.pos_x     = px;
    assign rsp.pos_y     = py;
    assign rsp.size_w    = sw;
    assign rsp.size_h    = sh;
    assign rsp.placement = pl;

endmodule

>>> sv/msg_prep.sv
// ----------------------------------------------------------------------------
// msg_prep: entry stage
// Clamps the tile count, picks the stack extent to split and loads the
// divider with its magnitude and the divisor count - 1.
// ----------------------------------------------------------------------------
module msg_prep
    import msg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [CNT_W-1:0] in_count,
    input  logic [IDX_W-1:0] in_index,
    output logic             out_valid,
    output div_t             out_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [CNT_W-1:0] n_cl;
    coord_t           ext;
    coord_t           mag;

    always_comb
    begin
        if (in_count > CNT_W'(MAX_TILES))
            n_cl = CNT_W'(MAX_TILES);
        else
            n_cl = in_count;

        ext = cfg.stack_vertical ? stack_h(cfg) : stack_w(cfg);
        mag = ext[COORD_W-1] ? -ext : ext;

        data_next.n   = n_cl;
        data_next.idx = in_index;
        data_next.neg = ext[COORD_W-1];
        // count of one or zero keeps the full extent: divide by one
        data_next.d   = (n_cl > CNT_W'(1)) ? DIV_W'(n_cl - CNT_W'(1)) : DIV_W'(1);
        data_next.rem = '0;
        data_next.dq  = mag[QUO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/msg_div_stage.sv
// ----------------------------------------------------------------------------
// msg_div_stage: one stage of the pipelined divider
// Runs a few restoring division steps and registers the partial result.
// ----------------------------------------------------------------------------
module msg_div_stage
    import msg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
            data_next = div_step(data_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/msg_place.sv
// ----------------------------------------------------------------------------
// msg_place: tile size, offset product and final placement
// First stage signs the quotient, decides tile or fallback and multiplies
// the tile size by the stack position; second stage forms the rectangle
// into the output register.
// ----------------------------------------------------------------------------
module msg_place
    import msg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  div_t       in_data,
    output logic       out_valid,
    output coord_t     pos_x,
    output coord_t     pos_y,
    output coord_t     size_w,
    output coord_t     size_h,
    output placement_t placement
);

    // stage A
    logic             geo_valid_reg;
    geo_t             geo_reg;
    geo_t             geo_next;
    coord_t           tq;
    logic [IDX_W-1:0] im1;
    logic [COORD_W+IDX_W-1:0] prod_full;

    // stage B
    logic       out_valid_reg;
    coord_t     x_reg, y_reg, w_reg, h_reg;
    coord_t     x_next, y_next, w_next, h_next;
    placement_t place_reg, place_next;

    coord_t sx, sy, sw, sh, bh, ms, stw, sth;
    logic   last;

    always_comb
    begin
        tq  = in_data.neg ? -$signed({2'b00, in_data.dq}) : $signed({2'b00, in_data.dq});
        im1 = in_data.idx - IDX_W'(1);
        prod_full = (COORD_W+IDX_W)'(unsigned'(tq)) * (COORD_W+IDX_W)'(im1);

        geo_next.n    = in_data.n;
        geo_next.idx  = in_data.idx;
        geo_next.th   = cfg.stack_vertical ? tq : stack_h(cfg);
        geo_next.tw   = cfg.stack_vertical ? stack_w(cfg) : tq;
        geo_next.prod = $signed(prod_full[COORD_W-1:0]);
        if (cfg.stack_vertical)
            geo_next.tile_ok = (tq > $signed({8'b0, cfg.bar_h}));
        else
            geo_next.tile_ok = (tq > COORD_W'(MIN_TILE_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            geo_valid_reg <= 1'b0;
        else if (adv)
            geo_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            geo_reg <= geo_next;
    end

    always_comb
    begin
        sx  = ext15(cfg.screen_x);
        sy  = ext15(cfg.screen_y);
        sw  = ext15(cfg.screen_w);
        sh  = ext15(cfg.screen_h);
        bh  = $signed({8'b0, cfg.bar_h});
        ms  = ext15(cfg.master_size);
        stw = stack_w(cfg);
        sth = stack_h(cfg);
        last = ({1'b0, geo_reg.idx} + CNT_W'(1)) == geo_reg.n;

        x_next = sx;
        y_next = sy + bh;
        w_next = sw - B2;
        h_next = sh - B2 - bh;
        place_next = PL_SINGLE;

        if (geo_reg.n == CNT_W'(1))
        begin
            place_next = PL_SINGLE;
        end
        else if (geo_reg.idx == '0)
        begin
            place_next = PL_MASTER;
            if (cfg.stack_pos == SP_BOTTOM)
            begin
                w_next = sw - B2;
                h_next = ms - B2;
            end
            else
            begin
                if (cfg.stack_pos == SP_LEFT)
                    x_next = sx + stw;
                w_next = ms - B2;
                h_next = sh - bh - B2;
            end
        end
        else if (geo_reg.tile_ok)
        begin
            place_next = PL_STACK;
            w_next = geo_reg.tw - B2;
            h_next = geo_reg.th - B2;
            if (cfg.stack_vertical)
            begin
                if (cfg.stack_pos == SP_LEFT || cfg.stack_pos == SP_BOTTOM)
                    x_next = sx;
                else
                    x_next = sx + ms;
                y_next = sy + geo_reg.prod + bh;
                if (cfg.stack_pos == SP_BOTTOM)
                    y_next = y_next + ms;
                // last tile runs down to the screen bottom
                if (last)
                    h_next = sh - y_next - B2;
            end
            else
            begin
                x_next = sx + geo_reg.prod;
                if (cfg.stack_pos != SP_LEFT && cfg.stack_pos != SP_BOTTOM)
                    x_next = x_next + ms;
                y_next = sy + bh;
                if (cfg.stack_pos == SP_BOTTOM)
                    y_next = y_next + ms;
                // last tile runs to the stack's right edge
                if (last)
                begin
                    if (cfg.stack_pos == SP_LEFT)
                        w_next = sx + stw - x_next - B2;
                    else
                        w_next = sw - x_next - B2;
                end
            end
        end
        else
        begin
            place_next = PL_FALLBACK;
            w_next = stw - B2;
            h_next = sth - B2;
            case (cfg.stack_pos)
                SP_LEFT:
                begin
                    x_next = sx;
                    y_next = sy + bh;
                end
                SP_BOTTOM:
                begin
                    // bar height left out here
                    x_next = sx;
                    y_next = sy + ms;
                end
                default:
                begin
                    x_next = sx + ms;
                    y_next = sy + bh;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= geo_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            place_reg <= place_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = x_reg;
    assign pos_y     = y_reg;
    assign size_w    = w_reg;
    assign size_h    = h_reg;
    assign placement = place_reg;

endmodule

>>> sv/msg_chk.sv
// ----------------------------------------------------------------------------
// msg_chk: port-level checker for the tile geometry unit
// Watches the request and response handshakes and the pipeline latency.
// ----------------------------------------------------------------------------
module msg_chk
    import msg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [17:0] pos_x,
    input logic signed [17:0] pos_y,
    input logic signed [17:0] size_w,
    input logic signed [17:0] size_h,
    input logic [1:0]         placement
);

    // a waiting response holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(size_w) && $stable(size_h) && $stable(placement))
        else $error("response changed while stalled");

    // a response only leaves when taken
    a_rsp_keep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(rsp_ready))
        else $error("response dropped without handshake");

    // a full, stalled output blocks new requests
    a_req_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while output stalled");

    // an accepted request whose pipeline never stalls shows up as a valid response
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 req_ready ##1 req_ready ##1 req_ready
            ##1 req_ready ##1 req_ready ##1 req_ready |=> rsp_valid)
        else $error("response missing after pipeline latency");

endmodule

bind master_stack_tile_geometry_unit msg_chk u_msg_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pos_x     (rsp.pos_x),
    .pos_y     (rsp.pos_y),
    .size_w    (rsp.size_w),
    .size_h    (rsp.size_h),
    .placement (rsp.placement)
);
